// ----- hdl/rcfd_pkg.sv -----
// shared types, constants and helpers for the rc frame decode and calibrate block
`default_nettype none

package rcfd_pkg;

  localparam int NUM_LANES    = 4;
  localparam int STICK_W      = 11;
  localparam int CEIL_W       = 10;
  localparam int FLOOR_W      = 11;
  localparam int SWITCH_W     = 2;
  localparam int STICK_SPAN   = 660;
  localparam int STICK_OFFSET = 1024;
  localparam int FRAME_W      = 48;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 11;
  // |v| * 660 with |v| <= 659 stays below 2^19
  localparam int NUM_W        = 19;
  localparam int DIV_STEPS    = NUM_W;
  localparam int CNT_W        = $clog2(DIV_STEPS + 1);

  typedef logic signed [STICK_W-1:0] stick_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CEIL_CH1  = 4'd0,
    REG_CEIL_CH2  = 4'd1,
    REG_CEIL_CH3  = 4'd2,
    REG_CEIL_CH4  = 4'd3,
    REG_FLOOR_CH1 = 4'd4,
    REG_FLOOR_CH2 = 4'd5,
    REG_FLOOR_CH3 = 4'd6,
    REG_FLOOR_CH4 = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic               start;
    stick_t             value;
    logic [CEIL_W-1:0]  ceil_val;
    logic [FLOOR_W-1:0] floor_val;
  } lane_req_t;

  typedef struct packed {
    logic   done;
    stick_t value;
  } lane_rsp_t;

  localparam stick_t SPAN_S = stick_t'(STICK_SPAN);

  function automatic logic stick_in_range(stick_t v);
    return (v < SPAN_S) && (v > -SPAN_S);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rcfd_lane.sv -----
// one stick lane: scales by 660 and divides by the calibration value bit-serially
`default_nettype none

module rcfd_lane (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rcfd_pkg::lane_req_t req,
  output rcfd_pkg::lane_rsp_t    rsp
);
  import rcfd_pkg::*;

  localparam int PROD_W = STICK_W + CEIL_W;

  logic               busy_r;
  logic               fin_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]   num_r;
  logic [FLOOR_W-1:0] rem_r;
  logic [FLOOR_W-1:0] den_r;
  logic               neg_r;
  logic               zero_r;

  logic [STICK_W-1:0] mag;
  logic [PROD_W-1:0]  prod;
  logic [FLOOR_W:0]   rem_sh;
  logic [FLOOR_W:0]   rem_diff;
  logic               take;
  logic [STICK_W-1:0] mag_sat;
  stick_t             result;

  always_comb begin
    mag      = req.value[STICK_W-1] ? STICK_W'(-req.value) : STICK_W'(req.value);
    prod     = PROD_W'(mag) * PROD_W'(STICK_SPAN);
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    take     = rem_sh >= {1'b0, den_r};
    rem_diff = rem_sh - {1'b0, den_r};
    // quotient sits in num_r once all steps are done
    mag_sat  = (num_r > NUM_W'(STICK_SPAN)) ? STICK_W'(STICK_SPAN) : STICK_W'(num_r);
    if (zero_r) begin
      result = '0;
    end else if (neg_r) begin
      result = stick_t'(-mag_sat);
    end else begin
      result = stick_t'(mag_sat);
    end
  end

  assign rsp.done  = fin_r;
  assign rsp.value = result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      cnt_r  <= CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r  <= prod[NUM_W-1:0];
      rem_r  <= '0;
      den_r  <= req.value[STICK_W-1] ? req.floor_val : {1'b0, req.ceil_val};
      neg_r  <= req.value[STICK_W-1];
      zero_r <= (req.value == '0);
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], take};
      // remainder stays below the divisor, so it fits
      rem_r <= take ? rem_diff[FLOOR_W-1:0] : rem_sh[FLOOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rcfd_merge.sv -----
// merges lane results into the held sticks and drives the result register
`default_nettype none

module rcfd_merge (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          load,
  input  wire logic                                          frame_ok,
  input  wire rcfd_pkg::lane_rsp_t [rcfd_pkg::NUM_LANES-1:0] lane_rsp,
  input  wire logic [rcfd_pkg::SWITCH_W-1:0]                 switch_left,
  input  wire logic [rcfd_pkg::SWITCH_W-1:0]                 switch_right,
  output logic                                               slot_free,
  output logic                                               out_tvalid,
  input  wire logic                                          out_tready,
  output logic [rcfd_pkg::FRAME_W-1:0]                       out_tdata,
  output logic                                               out_tuser
);
  import rcfd_pkg::*;

  logic [NUM_LANES-1:0][STICK_W-1:0] held_r;
  logic [NUM_LANES-1:0][STICK_W-1:0] held_nxt;
  logic                              out_tvalid_r;
  logic [FRAME_W-1:0]                out_tdata_r;
  logic                              out_tuser_r;
  logic [FRAME_W-1:0]                tdata_nxt;

  // sticks occupy the low bits, switches the top four
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      held_nxt[i] = frame_ok ? lane_rsp[i].value : held_r[i];
    end
    tdata_nxt = {switch_right, switch_left, held_nxt[NUM_LANES-1:0]};
  end

  assign slot_free  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load) begin
        held_r       <= held_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= frame_ok;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rc_frame_decode_calibrate.sv -----
// top level: frame unpack, calibration registers, control and four stick lanes
//
//  channel | dir | handshake                | payload
//  in_     | in  | in_tvalid / in_tready    | in_tdata: six frame bytes
//  out_    | out | out_tvalid / out_tready  | out_tdata: sticks, switches; out_tuser: updated
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// a frame is worked on from accept to a valid result by the 19-step serial divider
// in each lane; the next frame is accepted no earlier than the cycle after the result
// is loaded, so the lanes work on one frame at a time.
// rst_n is synchronous: calibration returns to 660, held sticks to zero.
// a stalled result waits in the output register; the lanes are then idle and
// one further frame can be worked on while the old result is still pending.
// cfg_ready is always high.
`default_nettype none

module rc_frame_decode_calibrate (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // frame_byte0 .. frame_byte5, byte0 in bits 7:0
  input  wire logic [rcfd_pkg::FRAME_W-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // stick_one, stick_two, stick_three, stick_four, switch_left, switch_right
  output logic [rcfd_pkg::FRAME_W-1:0]           out_tdata,
  // channels_updated
  output logic                                   out_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rcfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rcfd_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  logic [NUM_LANES-1:0][CEIL_W-1:0]  ceil_r;
  logic [NUM_LANES-1:0][FLOOR_W-1:0] floor_r;
  logic [FRAME_W-1:0]                frame_r;

  stick_t                        raw_v   [NUM_LANES];
  lane_req_t [NUM_LANES-1:0]     lane_req;
  lane_rsp_t [NUM_LANES-1:0]     lane_rsp;
  logic                          frame_ok;
  logic                          all_done;
  logic                          lane_start;
  logic                          merge_load;
  logic                          slot_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        ceil_r[i]  <= CEIL_W'(STICK_SPAN);
        floor_r[i] <= FLOOR_W'(STICK_SPAN);
      end
    end else if (cfg_valid) begin
      if (cfg_index inside {[REG_CEIL_CH1:REG_CEIL_CH4]}) begin
        ceil_r[cfg_index[1:0]] <= cfg_data[CEIL_W-1:0];
      end else if (cfg_index inside {[REG_FLOOR_CH1:REG_FLOOR_CH4]}) begin
        floor_r[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      frame_r <= in_tdata;
    end
  end

  // the four 11-bit channels sit back to back in the first 44 frame bits
  always_comb begin
    frame_ok = 1'b1;
    all_done = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      raw_v[i]             = stick_t'(frame_r[i*STICK_W +: STICK_W] - STICK_W'(STICK_OFFSET));
      frame_ok             = frame_ok & stick_in_range(raw_v[i]);
      all_done             = all_done & lane_rsp[i].done;
      lane_req[i].start    = lane_start;
      lane_req[i].value    = raw_v[i];
      lane_req[i].ceil_val = ceil_r[i];
      lane_req[i].floor_val = floor_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_START;
      ST_START: state_nxt = ST_RUN;
      ST_RUN:   if (all_done) state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    lane_start = 1'b0;
    merge_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_START: lane_start = 1'b1;
      ST_RUN:   ;
      ST_DONE:  merge_load = slot_free;
      default:  ;
    endcase
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rcfd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (lane_req[g]),
      .rsp   (lane_rsp[g])
    );
  end

  rcfd_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (merge_load),
    .frame_ok     (frame_ok),
    .lane_rsp     (lane_rsp),
    .switch_left  (frame_r[FRAME_W-1 -: SWITCH_W]),
    .switch_right (frame_r[FRAME_W-1-SWITCH_W -: SWITCH_W]),
    .slot_free    (slot_free),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule

`default_nettype wire

// ----- hdl/rcfd_checker.sv -----
// port-level checks for the rc frame decode and calibrate block, bound to the top level
`default_nettype none

module rcfd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [rcfd_pkg::FRAME_W-1:0]    out_tdata,
  input wire logic                            out_tuser
);
  import rcfd_pkg::*;

  logic sticks_ok;

  always_comb begin
    sticks_ok = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      sticks_ok = sticks_ok &
                  ($signed(out_tdata[i*STICK_W +: STICK_W]) <= SPAN_S) &
                  ($signed(out_tdata[i*STICK_W +: STICK_W]) >= -SPAN_S);
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // calibrated sticks are saturated to the span
  a_stick_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sticks_ok)
    else $error("stick outside calibrated span");

  // one frame at a time: no request taken right after one was accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second frame accepted back to back");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // no result appears straight after an accept when nothing was pending
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind rc_frame_decode_calibrate rcfd_checker u_rcfd_checker (.*);

`default_nettype wire
